/* hdl/torus_radius_neighbor_count_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the torus radius neighbor count core
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef TORUS_RADIUS_NEIGHBOR_COUNT_CORE_ASSERT_SVH
`define TORUS_RADIUS_NEIGHBOR_COUNT_CORE_ASSERT_SVH

// condition holds at every edge
`define TRNC_ASSERT_HOLDS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define TRNC_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define TRNC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/trnc_pkg.sv */
// ----------------------------------------------------------------------------
// trnc_pkg
// Widths, register map, sequencer states and shared types of the torus
// radius neighbor count core.
// ----------------------------------------------------------------------------
package trnc_pkg;

	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int COORD_BITS_DEF  = 12;

	localparam int FUNC_W    = 1;
	localparam int ENTRY_W   = 10;
	localparam int KIND_W    = 8;
	localparam int AGE_W     = 16;
	localparam int VIEW_W    = 12;
	localparam int LAND_W    = 13;
	localparam int EDGE_W    = 2;
	localparam int RCOUNT_W  = 11;
	localparam int COUNT_W   = 11;
	localparam int LIMIT_W   = 2 * VIEW_W;
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
	localparam logic [EDGE_W-1:0]  EDGE_TORUS = 2'd1;
	localparam logic [LAND_W-1:0]  LAND_RESET = 13'd4096;

	localparam logic [FUNC_W-1:0] FUNC_LOAD  = 1'b0;
	localparam logic [FUNC_W-1:0] FUNC_QUERY = 1'b1;

	typedef enum logic [2:0] {
		REG_EDGE_MODE   = 3'd0,
		REG_LAND_WIDTH  = 3'd1,
		REG_LAND_HEIGHT = 3'd2,
		REG_TGT_RES     = 3'd3,
		REG_TGT_OBS     = 3'd4,
		REG_MIN_AGE     = 3'd5,
		REG_RES_COUNT   = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LIM,
		ST_LIM2,
		ST_X,
		ST_Y,
		ST_ACC,
		ST_OUT
	} trnc_state_t;

	typedef struct packed {
		logic en;
		logic torus;
		logic raw_sel;
	} sq_ctrl_t;

	function automatic int mag_width(int coord_bits);
		return ((coord_bits >= LAND_W) ? coord_bits : LAND_W) + 2;
	endfunction

endpackage

/* hdl/trnc_sq_unit.sv */
// ----------------------------------------------------------------------------
// trnc_sq_unit
// Shared squaring unit: picks the smallest axis offset magnitude (direct or
// shifted by the landscape size in torus mode), or a raw radius, and
// registers its square.
// ----------------------------------------------------------------------------
module trnc_sq_unit import trnc_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                                    clk,
	input  sq_ctrl_t                                ctrl,
	input  logic [VIEW_W-1:0]                       raw,
	input  logic [COORD_BITS-1:0]                   obs,
	input  logic [COORD_BITS-1:0]                   pt,
	input  logic [LAND_W-1:0]                       size,
	output logic [2*mag_width(COORD_BITS)-1:0]      prod_q
);

	localparam int DW = mag_width(COORD_BITS);

	function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
		return v[DW-1] ? DW'(-v) : DW'(v);
	endfunction

	logic signed [DW-1:0] d_dir;
	logic signed [DW-1:0] d_plus;
	logic signed [DW-1:0] d_minus;
	logic [DW-1:0]        m_dir;
	logic [DW-1:0]        m_plus;
	logic [DW-1:0]        m_minus;
	logic [DW-1:0]        m_wrap;
	logic [DW-1:0]        m_sel;

	always_comb begin
		d_dir   = $signed(DW'(obs)) - $signed(DW'(pt));
		d_plus  = d_dir + $signed(DW'(size));
		d_minus = d_dir - $signed(DW'(size));
		m_dir   = mag(d_dir);
		m_plus  = mag(d_plus);
		m_minus = mag(d_minus);
		m_wrap  = m_dir;
		if (m_plus < m_wrap) begin
			m_wrap = m_plus;
		end
		if (m_minus < m_wrap) begin
			m_wrap = m_minus;
		end
		if (ctrl.raw_sel) begin
			m_sel = DW'(raw);
		end else if (ctrl.torus) begin
			m_sel = m_wrap;
		end else begin
			m_sel = m_dir;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			prod_q <= m_sel * m_sel;
		end
	end

endmodule

/* hdl/torus_radius_neighbor_count_core.sv */
// ----------------------------------------------------------------------------
// torus_radius_neighbor_count_core
// Counts stored resource points of the target type and minimum age that lie
// within an observer's view radius, with optional torus wrap distance.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_ready   func, entry_index, pos_x, pos_y,
//                                             kind, age, view_radius
//   out      source     out_valid / out_ready seen_count, record_updated
//   cfg      APB        psel/penable/pwrite   paddr, pwdata, prdata
//
// A load transaction is written without leaving the idle state. For a query,
// N being resource_count capped at TABLE_DEPTH, the single squarer takes the
// radius once, then x and y of every entry, each entry closing with an
// accumulate step; a query skipped by observer type or by a zero N goes straight
// to the output state. No clearing pass: the table is undefined until loaded.
// The result waits in an output register; the next transaction is taken
// while it waits, and a finished query holds until that register frees up.
// ----------------------------------------------------------------------------
module torus_radius_neighbor_count_core import trnc_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int COORD_BITS  = COORD_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [FUNC_W-1:0]      func,
	input  logic [ENTRY_W-1:0]     entry_index,
	input  logic [COORD_BITS-1:0]  pos_x,
	input  logic [COORD_BITS-1:0]  pos_y,
	input  logic [KIND_W-1:0]      kind,
	input  logic [AGE_W-1:0]       age,
	input  logic [VIEW_W-1:0]      view_radius,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [COUNT_W-1:0]     seen_count,
	output logic                   record_updated,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_ADDR_W-1:0]  paddr,
	input  logic [APB_DATA_W-1:0]  pwdata,
	output logic [APB_DATA_W-1:0]  prdata,
	output logic                   pready
);

	localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int NW     = (CNT_W > RCOUNT_W) ? CNT_W : RCOUNT_W;
	localparam int EW     = (CNT_W > ENTRY_W) ? CNT_W : ENTRY_W;
	localparam int CW     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
	localparam int PROD_W = 2 * mag_width(COORD_BITS);

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [KIND_W-1:0]     kind;
		logic [AGE_W-1:0]      age;
	} point_t;

	logic [EDGE_W-1:0]   edge_mode_q;
	logic [LAND_W-1:0]   land_width_q;
	logic [LAND_W-1:0]   land_height_q;
	logic [KIND_W-1:0]   tgt_res_q;
	logic [KIND_W-1:0]   tgt_obs_q;
	logic [AGE_W-1:0]    min_age_q;
	logic [RCOUNT_W-1:0] res_count_q;

	point_t              mem [TABLE_DEPTH];
	point_t              rd_q;
	logic                mem_we;
	logic [IDX_W-1:0]    wr_addr;
	logic [IDX_W-1:0]    rd_addr;
	logic [CNT_W-1:0]    rd_idx;

	trnc_state_t         state_q;
	trnc_state_t         state_d;
	logic [CNT_W-1:0]    idx_q;
	logic [CNT_W-1:0]    idx_nxt;
	logic [CNT_W-1:0]    n_q;
	logic [CNT_W-1:0]    n_d;
	logic [NW-1:0]       n_full;
	logic [COUNT_W-1:0]  count_q;
	logic                touched_q;
	logic [COORD_BITS-1:0] obs_x_q;
	logic [COORD_BITS-1:0] obs_y_q;
	logic [VIEW_W-1:0]   view_q;
	logic [LIMIT_W-1:0]  limit_q;
	logic [PROD_W-1:0]   sqx_q;
	logic [PROD_W-1:0]   prod;
	logic [PROD_W:0]     dist_sq;
	logic                hit;
	logic                qualifies;

	logic                in_fire;
	logic                query_fire;
	logic                skip_walk;
	logic                cfg_wr;
	logic                out_load;
	logic                out_valid_q;
	logic [COUNT_W-1:0]  seen_q;
	logic                rec_q;

	sq_ctrl_t            sq_ctrl;
	logic [COORD_BITS-1:0] sq_obs;
	logic [COORD_BITS-1:0] sq_pt;
	logic [LAND_W-1:0]   sq_size;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_mode_q   <= '0;
			land_width_q  <= LAND_RESET;
			land_height_q <= LAND_RESET;
			tgt_res_q     <= '0;
			tgt_obs_q     <= '0;
			min_age_q     <= '0;
			res_count_q   <= '0;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[4:2]))
				REG_EDGE_MODE:   edge_mode_q   <= pwdata[EDGE_W-1:0];
				REG_LAND_WIDTH:  land_width_q  <= pwdata[LAND_W-1:0];
				REG_LAND_HEIGHT: land_height_q <= pwdata[LAND_W-1:0];
				REG_TGT_RES:     tgt_res_q     <= pwdata[KIND_W-1:0];
				REG_TGT_OBS:     tgt_obs_q     <= pwdata[KIND_W-1:0];
				REG_MIN_AGE:     min_age_q     <= pwdata[AGE_W-1:0];
				REG_RES_COUNT:   res_count_q   <= pwdata[RCOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[4:2]))
			REG_EDGE_MODE:   prdata = APB_DATA_W'(edge_mode_q);
			REG_LAND_WIDTH:  prdata = APB_DATA_W'(land_width_q);
			REG_LAND_HEIGHT: prdata = APB_DATA_W'(land_height_q);
			REG_TGT_RES:     prdata = APB_DATA_W'(tgt_res_q);
			REG_TGT_OBS:     prdata = APB_DATA_W'(tgt_obs_q);
			REG_MIN_AGE:     prdata = APB_DATA_W'(min_age_q);
			REG_RES_COUNT:   prdata = APB_DATA_W'(res_count_q);
			default:         prdata = '0;
		endcase
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign in_fire    = in_valid & in_ready;
	assign query_fire = in_fire & (func == FUNC_QUERY);
	assign mem_we     = in_fire & (func == FUNC_LOAD) & (EW'(entry_index) < EW'(TABLE_DEPTH));
	assign wr_addr    = IDX_W'(entry_index);

	assign n_full    = (NW'(res_count_q) > NW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH)
	                                                         : NW'(res_count_q);
	assign n_d       = n_full[CNT_W-1:0];
	assign skip_walk = (kind != tgt_obs_q) | (n_d == '0);

	assign idx_nxt = idx_q + 1'b1;
	assign rd_idx  = (state_q == ST_ACC) ? idx_nxt : idx_q;
	assign rd_addr = rd_idx[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= '{x: pos_x, y: pos_y, kind: kind, age: age};
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		sq_ctrl  = '{en: 1'b0, torus: (edge_mode_q == EDGE_TORUS), raw_sel: 1'b0};
		sq_obs   = obs_x_q;
		sq_pt    = rd_q.x;
		sq_size  = land_width_q;
		case (state_q)
			ST_IDLE: begin
				if (query_fire) begin
					state_d = skip_walk ? ST_OUT : ST_LIM;
				end
			end
			ST_LIM: begin
				sq_ctrl.en      = 1'b1;
				sq_ctrl.raw_sel = 1'b1;
				state_d         = ST_LIM2;
			end
			ST_LIM2: begin
				state_d = ST_X;
			end
			ST_X: begin
				sq_ctrl.en = 1'b1;
				state_d    = ST_Y;
			end
			ST_Y: begin
				sq_ctrl.en = 1'b1;
				sq_obs     = obs_y_q;
				sq_pt      = rd_q.y;
				sq_size    = land_height_q;
				state_d    = ST_ACC;
			end
			ST_ACC: begin
				state_d = (idx_nxt == n_q) ? ST_OUT : ST_X;
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	trnc_sq_unit #(
		.COORD_BITS(COORD_BITS)
	) u_sq (
		.clk    (clk),
		.ctrl   (sq_ctrl),
		.raw    (view_q),
		.obs    (sq_obs),
		.pt     (sq_pt),
		.size   (sq_size),
		.prod_q (prod)
	);

	assign qualifies = (rd_q.kind == tgt_res_q) & (rd_q.age >= min_age_q);
	assign dist_sq   = {1'b0, sqx_q} + {1'b0, prod};
	assign hit       = dist_sq <= (PROD_W + 1)'(limit_q);

	always_ff @(posedge clk) begin
		if (query_fire) begin
			obs_x_q <= pos_x;
			obs_y_q <= pos_y;
			view_q  <= view_radius;
			n_q     <= n_d;
		end
		if (state_q == ST_LIM2) begin
			limit_q <= prod[LIMIT_W-1:0];
		end
		if (state_q == ST_Y) begin
			sqx_q <= prod;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			count_q   <= '0;
			touched_q <= 1'b0;
		end else if (query_fire) begin
			idx_q     <= '0;
			count_q   <= '0;
			touched_q <= 1'b0;
		end else if (state_q == ST_ACC) begin
			idx_q <= idx_nxt;
			if (qualifies) begin
				touched_q <= 1'b1;
				if (hit && (count_q != COUNT_MAX)) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			seen_q <= count_q;
			rec_q  <= touched_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign seen_count     = seen_q;
	assign record_updated = rec_q;

	`include "torus_radius_neighbor_count_core_assert.svh"

	`TRNC_ASSERT_IMPL(a_walk_in_range, (state_q == ST_X), (idx_q < n_q),
		"walk index beyond entry count")
	`TRNC_ASSERT_HOLDS(a_count_le_walked, (CW'(count_q) <= CW'(idx_q)),
		"count exceeds entries walked")
	`TRNC_ASSERT_IMPL(a_no_touch_no_count, (out_valid_q && !rec_q), (seen_q == '0),
		"count without qualifying entry")
	`TRNC_ASSERT_NEXT(a_load_one_cycle, (in_fire && (func == FUNC_LOAD)),
		(state_q == ST_IDLE), "load transaction left idle")

endmodule
